>>> sv/uts_pkg.sv
// Shared types, status codes and the constant symbol table for the UTF-8 symbol tokenizer.
`default_nettype none
package uts_pkg;

  localparam int SYMBOL_COUNT = 178;
  localparam int CP_W         = 21;
  localparam int MAX_RES      = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_CONT = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_UNSUP    = 3'd4;

  typedef struct packed {
    logic [7:0] tok;
    logic       is_stat;
    logic [2:0] code;
  } res_t;

  typedef struct packed {
    logic [2:0]             cnt;
    res_t [MAX_RES-1:0]     ent;
  } bundle_t;

  localparam logic [CP_W-1:0] SYM_TABLE [SYMBOL_COUNT] = '{
    21'h5F, 21'h3B, 21'h3A, 21'h2C, 21'h2E, 21'h21, 21'h3F, 21'hA1, 21'hBF, 21'h2014,
    21'h2026, 21'h22, 21'hAB, 21'hBB, 21'h201C, 21'h201D, 21'h20,
    21'h41, 21'h42, 21'h43, 21'h44, 21'h45, 21'h46, 21'h47, 21'h48, 21'h49, 21'h4A,
    21'h4B, 21'h4C, 21'h4D,
    21'h4E, 21'h4F, 21'h50, 21'h51, 21'h52, 21'h53, 21'h54, 21'h55, 21'h56, 21'h57,
    21'h58, 21'h59, 21'h5A,
    21'h61, 21'h62, 21'h63, 21'h64, 21'h65, 21'h66, 21'h67, 21'h68, 21'h69, 21'h6A,
    21'h6B, 21'h6C, 21'h6D,
    21'h6E, 21'h6F, 21'h70, 21'h71, 21'h72, 21'h73, 21'h74, 21'h75, 21'h76, 21'h77,
    21'h78, 21'h79, 21'h7A,
    21'h251, 21'h250, 21'h252, 21'hE6, 21'h253, 21'h299, 21'h3B2, 21'h254, 21'h255, 21'hE7,
    21'h257, 21'h256, 21'hF0, 21'h2A4, 21'h259, 21'h258, 21'h25A, 21'h25B, 21'h25C, 21'h25D,
    21'h25E, 21'h25F, 21'h284, 21'h261, 21'h260, 21'h262, 21'h29B, 21'h266, 21'h267, 21'h127,
    21'h265, 21'h29C, 21'h268, 21'h26A, 21'h29D, 21'h26D, 21'h26C, 21'h26B, 21'h26E, 21'h29F,
    21'h271, 21'h26F, 21'h270, 21'h14B, 21'h273, 21'h272, 21'h274, 21'hF8, 21'h275, 21'h278,
    21'h3B8, 21'h153, 21'h276, 21'h298, 21'h279, 21'h27A, 21'h27E, 21'h27B, 21'h280, 21'h281,
    21'h27D, 21'h282, 21'h283, 21'h288, 21'h2A7, 21'h289, 21'h28A, 21'h28B, 21'h2C71, 21'h28C,
    21'h263, 21'h264, 21'h28D, 21'h3C7, 21'h28E, 21'h28F, 21'h291, 21'h290, 21'h292, 21'h294,
    21'h2A1, 21'h295, 21'h2A2, 21'h1C0, 21'h1C1, 21'h1C2, 21'h1C3, 21'h2C8, 21'h2CC, 21'h2D0,
    21'h2D1, 21'h2BC, 21'h2B4, 21'h2B0, 21'h2B1, 21'h2B2, 21'h2B7, 21'h2E0, 21'h2E4, 21'h2DE,
    21'h2193, 21'h2191, 21'h2192, 21'h2197, 21'h2198, 21'h27, 21'h329, 21'h27, 21'h1D7B
  };

  // {found, index}; lowest matching index wins
  function automatic logic [8:0] sym_lookup(input logic [CP_W-1:0] cp);
    logic       found;
    logic [7:0] idx;
    found = 1'b0;
    idx   = 8'd0;
    for (int i = SYMBOL_COUNT - 1; i >= 0; i--) begin
      if (SYM_TABLE[i] == cp) begin
        found = 1'b1;
        idx   = 8'(i);
      end
    end
    return {found, idx};
  endfunction

endpackage
`default_nettype wire

>>> sv/uts_decode.sv
// UTF-8 decode state, symbol match and per-byte result bundle.
`default_nettype none
module uts_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       byte_in,
  input  wire logic             end_in,
  output uts_pkg::bundle_t      bun
);
  import uts_pkg::*;

  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            lead_r, lead_nxt;
  logic [2:0]      stat_r, stat_nxt;
  logic            bad_r, bad_nxt;

  logic            utf8_err;
  logic            have;
  logic [CP_W-1:0] cp;
  logic [8:0]      lk;
  logic            emit_lead, emit_pair;
  logic [2:0]      code_v;
  logic [2:0]      n;

  always_comb begin
    rem_nxt   = rem_r;
    part_nxt  = part_r;
    lead_nxt  = lead_r;
    stat_nxt  = stat_r;
    bad_nxt   = bad_r;
    have      = 1'b0;
    cp        = '0;
    emit_lead = 1'b0;
    emit_pair = 1'b0;
    code_v    = ST_OK;
    n         = 3'd0;
    bun       = '0;
    utf8_err  = (stat_r == ST_BAD_LEAD) || (stat_r == ST_BAD_CONT) || (stat_r == ST_TRUNC);

    if (!utf8_err) begin
      if (rem_r == 2'd0) begin
        if (byte_in[7] == 1'b0) begin
          cp   = {13'd0, byte_in};
          have = 1'b1;
        end else if (byte_in[7:5] == 3'b110) begin
          part_nxt = {16'd0, byte_in[4:0]};
          rem_nxt  = 2'd1;
          bad_nxt  = 1'b0;
        end else if (byte_in[7:4] == 4'b1110) begin
          part_nxt = {17'd0, byte_in[3:0]};
          rem_nxt  = 2'd2;
          bad_nxt  = 1'b0;
        end else if (byte_in[7:3] == 5'b11110) begin
          part_nxt = {18'd0, byte_in[2:0]};
          rem_nxt  = 2'd3;
          bad_nxt  = 1'b0;
        end else begin
          stat_nxt = ST_BAD_LEAD;
        end
      end else begin
        if (byte_in[7:6] != 2'b10) begin
          bad_nxt = 1'b1;
        end
        part_nxt = {part_r[CP_W-7:0], byte_in[5:0]};
        rem_nxt  = rem_r - 2'd1;
        if (rem_nxt == 2'd0) begin
          if (bad_nxt) begin
            stat_nxt = ST_BAD_CONT;
          end else begin
            cp   = part_nxt;
            have = 1'b1;
          end
        end
      end
    end

    lk = sym_lookup(cp);
    if (have) begin
      if (!lk[8]) begin
        if (stat_r == ST_OK) begin
          stat_nxt = ST_UNSUP;
        end
      end else if (stat_r == ST_OK) begin
        emit_lead = !lead_r;
        emit_pair = 1'b1;
        lead_nxt  = 1'b1;
      end
    end

    if (emit_lead) begin
      bun.ent[n[1:0]] = '{tok: 8'd0, is_stat: 1'b0, code: ST_OK};
      n = n + 3'd1;
    end
    if (emit_pair) begin
      bun.ent[n[1:0]] = '{tok: lk[7:0], is_stat: 1'b0, code: ST_OK};
      n = n + 3'd1;
      bun.ent[n[1:0]] = '{tok: 8'd0, is_stat: 1'b0, code: ST_OK};
      n = n + 3'd1;
    end
    if (end_in) begin
      code_v = stat_nxt;
      if (!((code_v == ST_BAD_LEAD) || (code_v == ST_BAD_CONT) || (code_v == ST_TRUNC))
          && (rem_nxt != 2'd0)) begin
        code_v = ST_TRUNC;
      end
      bun.ent[n[1:0]] = '{tok: 8'd0, is_stat: 1'b1, code: code_v};
      n = n + 3'd1;
      rem_nxt  = 2'd0;
      part_nxt = '0;
      lead_nxt = 1'b0;
      stat_nxt = ST_OK;
      bad_nxt  = 1'b0;
    end
    bun.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= '0;
      lead_r <= 1'b0;
      stat_r <= ST_OK;
      bad_r  <= 1'b0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
      lead_r <= lead_nxt;
      stat_r <= stat_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/uts_outq.sv
// Result bundle register that hands out one result per output transaction.
`default_nettype none
module uts_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load_req,
  input  wire uts_pkg::bundle_t bun,
  output logic                  load_ok,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_token_id,
  output logic                  out_is_status,
  output logic [2:0]            out_status_code,
  output logic                  out_run_last
);
  import uts_pkg::*;

  logic                 vld_r;
  logic [1:0]           ptr_r;
  logic [2:0]           cnt_r;
  res_t [MAX_RES-1:0]   ent_r;
  logic                 take;
  logic                 last;
  logic                 load;

  assign last      = ({1'b0, ptr_r} + 3'd1) == cnt_r;
  assign take      = vld_r && !out_stall;
  assign load_ok   = !vld_r || (take && last);
  assign load      = load_req && load_ok && (bun.cnt != 3'd0);
  assign out_valid = vld_r;

  assign out_token_id    = ent_r[ptr_r].tok;
  assign out_is_status   = ent_r[ptr_r].is_stat;
  assign out_status_code = ent_r[ptr_r].code;
  assign out_run_last    = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ptr_r <= 2'd0;
      cnt_r <= 3'd0;
    end else if (load) begin
      vld_r <= 1'b1;
      ptr_r <= 2'd0;
      cnt_r <= bun.cnt;
    end else if (take && last) begin
      vld_r <= 1'b0;
    end else if (take) begin
      ptr_r <= ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= bun.ent;
    end
  end

endmodule
`default_nettype wire

>>> sv/utf8_symbol_tokenizer_top.sv
// UTF-8 symbol tokenizer top level: input register, decoder and result queue.
// Input channel: one text byte per transaction (in_text_byte), with in_text_end
// flagging the last byte of a text. Output channel: one result per transaction,
// either a symbol token (out_is_status low) or the end-of-text status
// (out_is_status high, out_status_code). out_run_last marks the final result
// caused by one input byte; a byte may cause none.
// Path: an accepted byte waits in the input register, is decoded from it
// combinationally, and its results are loaded into the output register
// once the queue can take them; the first is then offered on the output.
// Throughput: one byte per cycle while out_stall is low and each byte yields
// at most one result. A byte with more results holds the output register
// until all are taken: the output port (one result a cycle) sets the rate.
// Stall: out_stall holds the current result; the input register keeps one
// byte waiting and in_stall rises only when that byte cannot move on.
// Reset (rst_n low, synchronous) clears decode state and empties both stages.
// Decode state also clears after each byte with in_text_end set.
`default_nettype none
module utf8_symbol_tokenizer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_text_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_token_id,
  output logic            out_is_status,
  output logic [2:0]      out_status_code,
  output logic            out_run_last
);
  import uts_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       load_ok;
  logic       step;
  logic       accept;
  bundle_t    bun;

  assign step     = in_vld_r && load_ok;
  assign in_stall = in_vld_r && !load_ok;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_text_byte;
      in_end_r  <= in_text_end;
    end
  end

  uts_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .end_in  (in_end_r),
    .bun     (bun)
  );

  uts_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_req        (in_vld_r),
    .bun             (bun),
    .load_ok         (load_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_id    (out_token_id),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_run_last    (out_run_last)
  );

endmodule
`default_nettype wire

>>> sv/uts_checker.sv
// Port-level checker for the UTF-8 symbol tokenizer, bound to the top level.
`default_nettype none
module uts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_token_id,
  input wire logic       out_is_status,
  input wire logic [2:0] out_status_code,
  input wire logic       out_run_last
);
  import uts_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_token_id) && $stable(out_is_status)
      && $stable(out_status_code) && $stable(out_run_last))
    else $error("stalled result changed");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_status |-> out_token_id == 8'd0 && out_run_last
      && out_status_code <= ST_UNSUP)
    else $error("bad status transaction");

  a_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_status |-> out_status_code == ST_OK
      && out_token_id < 8'(SYMBOL_COUNT))
    else $error("bad token transaction");

endmodule

bind utf8_symbol_tokenizer_top uts_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_token_id    (out_token_id),
  .out_is_status   (out_is_status),
  .out_status_code (out_status_code),
  .out_run_last    (out_run_last)
);
`default_nettype wire
